// ===== rtl/row_group_batch_layout_assert.svh =====
// Assertion macros for the row group batch layout block.
`ifndef ROW_GROUP_BATCH_LAYOUT_ASSERT_SVH
`define ROW_GROUP_BATCH_LAYOUT_ASSERT_SVH

`ifndef SYNTHESIS
`define RGBL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbl: same-cycle check failed");
`define RGBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbl: next-cycle check failed");
`else
`define RGBL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define RGBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rgbl_pkg.sv =====
package rgbl_pkg;

  localparam int MAX_ROW_GROUPS_DEF  = 1024;
  localparam int FILE_INDEX_BITS_DEF = 16;

  localparam int ROW_W  = 63;
  localparam int FILE_W = 16;
  localparam int CNT_IN_W = 64;
  localparam int GIDX_W = 32;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index taken from paddr[2]
  localparam logic REG_INVALID_FILE_INDEX = 1'b0;
  localparam logic [FILE_W-1:0] INVALID_FILE_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_SPLIT  = 2'd0,
    REQ_SLICE  = 2'd1,
    REQ_COUNT  = 2'd2,
    REQ_SELECT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_UNBOUND  = 3'd1,
    ST_NO_META  = 3'd2,
    ST_NEGATIVE = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_RANGE    = 3'd5,
    ST_ORDER    = 3'd6,
    ST_FULL     = 3'd7
  } status_t;

endpackage

// ===== rtl/rgbl_in_if.sv =====
interface rgbl_in_if import rgbl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic signed [CNT_IN_W-1:0] row_count;
  logic signed [GIDX_W-1:0]   group_index;
  logic [FILE_W-1:0]          slice_file;
  logic                       has_metadata;

  modport source (output valid, req_type, row_count, group_index, slice_file,
                  has_metadata, input ready);
  modport sink   (input valid, req_type, row_count, group_index, slice_file,
                  has_metadata, output ready);
endinterface

// ===== rtl/rgbl_out_if.sv =====
interface rgbl_out_if import rgbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ROW_W-1:0]  file_row_start;
  logic [ROW_W-1:0]  batch_row_start;
  logic [ROW_W-1:0]  run_rows;
  logic [FILE_W-1:0] run_file;

  modport source (output valid, status, file_row_start, batch_row_start, run_rows,
                  run_file, input ready);
  modport sink   (input valid, status, file_row_start, batch_row_start, run_rows,
                  run_file, output ready);
endinterface

// ===== rtl/row_group_batch_layout.sv =====
// Row group batch layout: turns a stream of split, slice, footer row-count and
// select beats into runs of a decoded batch (file row start, batch row start,
// row count, file index), or one error status after which the block stays
// silent until the next begin-split. One beat is accepted every cycle while
// the input stage can advance; a beat is held in the input stage, which also
// captures the registered read of the group tables, and then in the result
// stage. The rate is set by the single table read port and the 64-bit add and
// compare in the result stage; input stalls only while a result waits to be
// taken. The group tables need no clearing after reset: only entries loaded
// since the last footer clear are ever read.
`include "row_group_batch_layout_assert.svh"

module row_group_batch_layout import rgbl_pkg::*; #(
  parameter int MAX_ROW_GROUPS  = MAX_ROW_GROUPS_DEF,
  parameter int FILE_INDEX_BITS = FILE_INDEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  rgbl_in_if.sink            in_bus,
  rgbl_out_if.source         out_bus,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int IDX_W = (MAX_ROW_GROUPS > 1) ? $clog2(MAX_ROW_GROUPS) : 1;
  localparam int CNT_W = $clog2(MAX_ROW_GROUPS + 1);
  localparam logic [31:0] FMASK32 = (FILE_INDEX_BITS >= 32) ? 32'hFFFF_FFFF :
                                    ((32'd1 << FILE_INDEX_BITS) - 32'd1);
  localparam logic [FILE_W-1:0] FILE_MASK = FMASK32[FILE_W-1:0];
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ROW_GROUPS);

  // configuration
  logic [FILE_W-1:0] invalid_file_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == REG_INVALID_FILE_INDEX);
  assign prdata = (paddr[2] == REG_INVALID_FILE_INDEX) ?
                  APB_DW'(invalid_file_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_file_r <= INVALID_FILE_RST;
    end else if (cfg_wr) begin
      invalid_file_r <= pwdata[FILE_W-1:0];
    end
  end

  // group tables
  logic [ROW_W-1:0] prefix_mem [MAX_ROW_GROUPS];
  logic [ROW_W-1:0] size_mem   [MAX_ROW_GROUPS];
  logic [ROW_W-1:0] rd_prefix_r, rd_size_r;
  logic [ROW_W-1:0] byp_prefix_r, byp_size_r;
  logic             byp_hit_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [ROW_W-1:0] mem_wprefix, mem_wsize;
  logic [IDX_W-1:0] mem_ra;

  // input stage
  logic                     s1_valid_r;
  req_t                     s1_req_r;
  logic [CNT_IN_W-1:0]      s1_count_r;
  logic [GIDX_W-1:0]        s1_gidx_r;
  logic [FILE_W-1:0]        s1_file_r;
  logic                     s1_meta_r;

  // block state
  logic [CNT_W-1:0]  group_count_r, group_count_nxt;
  logic [ROW_W-1:0]  footer_total_r, footer_total_nxt;
  logic [IDX_W-1:0]  last_sel_r, last_sel_nxt;
  logic              last_sel_valid_r, last_sel_valid_nxt;
  logic [ROW_W-1:0]  batch_offset_r, batch_offset_nxt;
  logic [FILE_W-1:0] current_file_r, current_file_nxt;
  logic              faulted_r, faulted_nxt;

  // result stage
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ROW_W-1:0]  out_file_start_r, out_batch_start_r, out_rows_r;
  logic [FILE_W-1:0] out_file_r;

  logic              in_accept, advance;
  logic              emit;
  status_t           emit_status;
  logic [ROW_W-1:0]  emit_file_start, emit_batch_start, emit_rows;
  logic [FILE_W-1:0] emit_file;

  logic [FILE_W-1:0] slice_file_m;
  logic [ROW_W:0]    footer_sum, batch_sum;
  logic [ROW_W-1:0]  sel_prefix, sel_size;
  logic [IDX_W-1:0]  sel_idx;
  logic              sel_range_bad;

  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;
  assign in_accept    = in_bus.valid && in_bus.ready;
  assign mem_ra       = in_bus.group_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prefix_mem[mem_wa] <= mem_wprefix;
      size_mem[mem_wa]   <= mem_wsize;
    end
    if (in_accept) begin
      rd_prefix_r <= prefix_mem[mem_ra];
      rd_size_r   <= size_mem[mem_ra];
    end
  end

  // forward a table write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      byp_hit_r    <= mem_we && (mem_wa == mem_ra);
      byp_prefix_r <= mem_wprefix;
      byp_size_r   <= mem_wsize;
      s1_req_r     <= req_t'(in_bus.req_type);
      s1_count_r   <= in_bus.row_count;
      s1_gidx_r    <= in_bus.group_index;
      s1_file_r    <= in_bus.slice_file;
      s1_meta_r    <= in_bus.has_metadata;
    end
  end

  assign sel_prefix    = byp_hit_r ? byp_prefix_r : rd_prefix_r;
  assign sel_size      = byp_hit_r ? byp_size_r   : rd_size_r;
  assign sel_idx       = s1_gidx_r[IDX_W-1:0];
  assign sel_range_bad = s1_gidx_r[GIDX_W-1] ||
                         ({1'b0, s1_gidx_r[GIDX_W-2:0]} >= GIDX_W'(group_count_r));
  assign slice_file_m  = s1_file_r & FILE_MASK;
  assign footer_sum    = {1'b0, footer_total_r} + {1'b0, s1_count_r[ROW_W-1:0]};
  assign batch_sum     = {1'b0, batch_offset_r} + {1'b0, sel_size};

  always_comb begin
    group_count_nxt    = group_count_r;
    footer_total_nxt   = footer_total_r;
    last_sel_nxt       = last_sel_r;
    last_sel_valid_nxt = last_sel_valid_r;
    batch_offset_nxt   = batch_offset_r;
    current_file_nxt   = current_file_r;
    faulted_nxt        = faulted_r;
    emit               = 1'b0;
    emit_status        = ST_RUN;
    emit_file_start    = '0;
    emit_batch_start   = '0;
    emit_rows          = '0;
    emit_file          = '0;
    mem_we             = 1'b0;
    mem_wa             = group_count_r[IDX_W-1:0];
    mem_wprefix        = footer_total_r;
    mem_wsize          = s1_count_r[ROW_W-1:0];

    if (advance) begin
      case (s1_req_r)
        REQ_SPLIT: begin
          batch_offset_nxt   = '0;
          faulted_nxt        = 1'b0;
          group_count_nxt    = '0;
          footer_total_nxt   = '0;
          last_sel_nxt       = '0;
          last_sel_valid_nxt = 1'b0;
        end
        REQ_SLICE: begin
          if (!faulted_r) begin
            if (slice_file_m == (invalid_file_r & FILE_MASK)) begin
              emit        = 1'b1;
              emit_status = ST_UNBOUND;
            end else if (!s1_meta_r) begin
              emit        = 1'b1;
              emit_status = ST_NO_META;
            end else begin
              current_file_nxt   = slice_file_m;
              group_count_nxt    = '0;
              footer_total_nxt   = '0;
              last_sel_nxt       = '0;
              last_sel_valid_nxt = 1'b0;
            end
          end
        end
        REQ_COUNT: begin
          if (!faulted_r) begin
            if (s1_count_r[CNT_IN_W-1]) begin
              emit        = 1'b1;
              emit_status = ST_NEGATIVE;
            end else if (footer_sum[ROW_W]) begin
              emit        = 1'b1;
              emit_status = ST_OVERFLOW;
            end else if (group_count_r >= CNT_MAX) begin
              emit        = 1'b1;
              emit_status = ST_FULL;
            end else begin
              mem_we           = 1'b1;
              footer_total_nxt = footer_sum[ROW_W-1:0];
              group_count_nxt  = group_count_r + CNT_W'(1);
            end
          end
        end
        REQ_SELECT: begin
          if (!faulted_r) begin
            if (sel_range_bad) begin
              emit        = 1'b1;
              emit_status = ST_RANGE;
            end else if (last_sel_valid_r && (sel_idx <= last_sel_r)) begin
              emit        = 1'b1;
              emit_status = ST_ORDER;
            end else if (batch_sum[ROW_W]) begin
              emit        = 1'b1;
              emit_status = ST_OVERFLOW;
            end else begin
              emit               = 1'b1;
              emit_status        = ST_RUN;
              emit_file_start    = sel_prefix;
              emit_batch_start   = batch_offset_r;
              emit_rows          = sel_size;
              emit_file          = current_file_r;
              batch_offset_nxt   = batch_sum[ROW_W-1:0];
              last_sel_nxt       = sel_idx;
              last_sel_valid_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      // any error result latches the fault
      if (emit && (emit_status != ST_RUN)) begin
        faulted_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      group_count_r    <= '0;
      footer_total_r   <= '0;
      last_sel_r       <= '0;
      last_sel_valid_r <= 1'b0;
      batch_offset_r   <= '0;
      current_file_r   <= '0;
      faulted_r        <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= emit;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      group_count_r    <= group_count_nxt;
      footer_total_r   <= footer_total_nxt;
      last_sel_r       <= last_sel_nxt;
      last_sel_valid_r <= last_sel_valid_nxt;
      batch_offset_r   <= batch_offset_nxt;
      current_file_r   <= current_file_nxt;
      faulted_r        <= faulted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_status_r      <= emit_status;
      out_file_start_r  <= emit_file_start;
      out_batch_start_r <= emit_batch_start;
      out_rows_r        <= emit_rows;
      out_file_r        <= emit_file;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = out_status_r;
  assign out_bus.file_row_start  = out_file_start_r;
  assign out_bus.batch_row_start = out_batch_start_r;
  assign out_bus.run_rows        = out_rows_r;
  assign out_bus.run_file        = out_file_r;

  `RGBL_ASSERT_IMPLIES(a_err_faulted, clk, rst_n, out_valid_r && (out_status_r != ST_RUN), faulted_r)
  `RGBL_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, group_count_r <= CNT_MAX)
  `RGBL_ASSERT_IMPLIES(a_last_in_table, clk, rst_n, last_sel_valid_r, CNT_W'(last_sel_r) < group_count_r)
  `RGBL_ASSERT_NEXT(a_offset_grows, clk, rst_n, advance && (s1_req_r != REQ_SPLIT), batch_offset_r >= $past(batch_offset_r))

endmodule
